/* src/c3ce_pkg.sv */
// ----------------------------------------------------------------------------
// c3ce_pkg: shared types and constants
// Item structs, register indexes, sizes and the sequencer state type for the
// 3x3 clamp-to-edge RGBA convolution block.
// ----------------------------------------------------------------------------
package c3ce_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W      = 11;            // width of size registers and counters
  localparam int CNT_W      = 21;            // pixel counts within a frame
  localparam int LS_DEPTH   = 4096;          // ring must hold 2*MAX_WIDTH+3 pixels
  localparam int LS_AW      = $clog2(LS_DEPTH);
  localparam int PIX_W      = 32;
  localparam int COEF_W     = 24;
  localparam int SUM_W      = 20;            // |sum| <= 9*255*128
  localparam int WGT_W      = 12;            // |weight| <= 9*128
  localparam int DEN_W      = 11;            // divisor magnitude
  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int NTAPS      = 9;
  localparam int TAP_W      = 4;
  localparam int NCH        = 4;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CTOP   = 3'd2;
  localparam logic [2:0] REG_CMID   = 3'd3;
  localparam logic [2:0] REG_CBOT   = 3'd4;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd512;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd512;
  localparam logic [COEF_W-1:0] CTOP_RST  = 24'd65280;
  localparam logic [COEF_W-1:0] CMID_RST  = 24'd16713215;
  localparam logic [COEF_W-1:0] CBOT_RST  = 24'd65280;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
    logic       zero_weight;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DSTART,
    S_DIV,
    S_OUT
  } seq_state_t;

endpackage

/* src/c3ce_ram.sv */
// ----------------------------------------------------------------------------
// c3ce_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module c3ce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/c3ce_div.sv */
// ----------------------------------------------------------------------------
// c3ce_div: four-lane restoring divider
// Unsigned magnitudes, one quotient bit per cycle per lane, shared divisor.
// Only the low 8 quotient bits are kept.
// ----------------------------------------------------------------------------
module c3ce_div
  import c3ce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SUM_W-1:0]     num [NCH],
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [7:0]           quo [NCH]
);

  logic [SUM_W-1:0]  dvd [NCH];
  logic [DEN_W-1:0]  rem [NCH];
  logic [DEN_W-1:0]  dsr;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DEN_W:0]    trial [NCH];
  logic              fits  [NCH];

  // trial subtract per lane
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      trial[i] = {rem[i], dvd[i][SUM_W-1]};
      fits[i]  = trial[i] >= {1'b0, dsr};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= den;
      for (int i = 0; i < NCH; i++) begin
        dvd[i] <= num[i];
        rem[i] <= '0;
        quo[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < NCH; i++) begin
        dvd[i] <= {dvd[i][SUM_W-2:0], 1'b0};
        if (fits[i]) begin
          rem[i] <= DEN_W'(trial[i] - {1'b0, dsr});
        end else begin
          rem[i] <= trial[i][DEN_W-1:0];
        end
        quo[i] <= {quo[i][6:0], fits[i]};
      end
    end
  end

endmodule

/* src/conv3x3_clamp_edge_rgba.sv */
// ----------------------------------------------------------------------------
// conv3x3_clamp_edge_rgba: streaming 3x3 RGBA convolution, clamp-to-edge
// Raster-order pixels go into a ring line store; each output reads its nine
// neighbours back from it, weights them and divides by the coefficient sum.
// ----------------------------------------------------------------------------
// Usage
//   in channel  (in_valid/in_ready/in_data): pixels in raster order, or drain
//     items that release one pending output each once the frame is complete.
//   out channel (out_valid/out_ready/out_data): filtered pixels in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): size and kernel
//     registers, always ready; write only while the block is idle. A width or
//     height write restarts the frame.
// Timing
//   An item that causes no output leaves the block idle and ready for the next
//   item. One that causes an output passes through acceptance, the nine line
//   store reads and their read latency, a set-up state, the bit-serial divider
//   (its quotient steps and the done cycle) and the load of the output
//   register; the next item is accepted only after that. With a zero
//   coefficient sum the divider is skipped.
// Reset
//   Registers take their reset values and the frame counters clear; the line
//   store needs no clearing, only pixels of the current frame are read.
// Stall
//   While out_ready is low the output register holds its item; the next
//   result waits before it, and in_ready stays low until it moves in.
// ----------------------------------------------------------------------------
module conv3x3_clamp_edge_rgba
  import c3ce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  // configuration
  logic [DIM_W-1:0]  image_width, image_height;
  logic [COEF_W-1:0] coeff_top_row, coeff_mid_row, coeff_bottom_row;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic              cfg_wr, size_wr;

  // frame counters
  logic [CNT_W-1:0]  received, emitted;
  logic [DIM_W-1:0]  rcol, rrow, ecol, erow;
  logic [LS_AW-1:0]  ebase;
  logic              full;

  seq_state_t        state, state_next;
  logic              accept, is_drain, pending, new_frame, do_write, start_emit;
  logic [CNT_W-1:0]  k_eff;

  // tap sequencing
  logic [TAP_W-1:0]  tap, rd_tap;
  logic              rd_vld, rd_en;
  logic [LS_AW-1:0]  rd_addr, row_up, row_dn, row_sel;
  logic [DIM_W-1:0]  col_l, col_r, col_sel;
  logic [PIX_W-1:0]  rd_data;
  logic [71:0]       coef_all;
  logic signed [7:0] coef;
  logic signed [SUM_W-1:0] prod [NCH];
  logic signed [SUM_W-1:0] acc [NCH];
  logic signed [WGT_W-1:0] weight;

  // divider
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_num [NCH];
  logic [DEN_W-1:0]  div_den;
  logic [7:0]        div_quo [NCH];
  logic [7:0]        res_ch  [NCH];
  logic              zero_w, last_out;

  // effective sizes
  always_comb begin
    priority if (image_width == '0) w_eff = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = image_width;
    priority if (image_height == '0) h_eff = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = image_height;
  end

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size_wr   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= WIDTH_RST;
      image_height     <= HEIGHT_RST;
      coeff_top_row    <= CTOP_RST;
      coeff_mid_row    <= CMID_RST;
      coeff_bottom_row <= CBOT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width      <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height     <= cfg_data[DIM_W-1:0];
        REG_CTOP:   coeff_top_row    <= cfg_data;
        REG_CMID:   coeff_mid_row    <= cfg_data;
        REG_CBOT:   coeff_bottom_row <= cfg_data;
        default: ;
      endcase
    end
  end

  // item decode
  assign accept     = in_valid && in_ready;
  assign is_drain   = (in_data.action == ACT_DRAIN);
  assign pending    = emitted < received;
  assign new_frame  = accept && full && !pending && !is_drain;
  assign do_write   = accept && !is_drain && !(full && pending);
  assign k_eff      = new_frame ? '0 : received;
  assign start_emit = accept && (full ? pending
                                      : (!is_drain && received >= CNT_W'(w_eff) + 1'b1));
  assign last_out   = (ecol == w_eff - 1'b1) && (erow == h_eff - 1'b1);

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      received <= '0;
      emitted  <= '0;
      rcol     <= '0;
      rrow     <= '0;
      full     <= 1'b0;
      ecol     <= '0;
      erow     <= '0;
      ebase    <= '0;
    end else begin
      if (new_frame) begin
        emitted <= '0;
        ecol    <= '0;
        erow    <= '0;
        ebase   <= '0;
      end
      if (do_write) begin
        received <= k_eff + 1'b1;
        if ((new_frame ? '0 : rcol) == w_eff - 1'b1) begin
          rcol <= '0;
          if ((new_frame ? '0 : rrow) == h_eff - 1'b1) begin
            full <= 1'b1;
            rrow <= '0;
          end else begin
            full <= 1'b0;
            rrow <= (new_frame ? '0 : rrow) + 1'b1;
          end
        end else begin
          full <= 1'b0;
          rcol <= (new_frame ? '0 : rcol) + 1'b1;
          if (new_frame) rrow <= '0;
        end
      end
      // step the output position once a result is loaded
      if (state == S_OUT && (!out_valid || out_ready)) begin
        emitted <= emitted + 1'b1;
        if (ecol == w_eff - 1'b1) begin
          ecol  <= '0;
          erow  <= erow + 1'b1;
          ebase <= ebase + LS_AW'(w_eff);
        end else begin
          ecol <= ecol + 1'b1;
        end
      end
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start_emit) state_next = S_READ;
      S_READ:   if (rd_vld && rd_tap == TAP_W'(NTAPS - 1)) state_next = S_DSTART;
      S_DSTART: state_next = zero_w ? S_OUT : S_DIV;
      S_DIV:    if (div_done) state_next = S_OUT;
      S_OUT:    if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    rd_en     = (state == S_READ) && (tap < TAP_W'(NTAPS));
    div_start = (state == S_DSTART);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // neighbour addresses, clamped at the frame edges
  always_comb begin
    row_up = (erow == '0) ? ebase : ebase - LS_AW'(w_eff);
    row_dn = (erow == h_eff - 1'b1) ? ebase : ebase + LS_AW'(w_eff);
    col_l  = (ecol == '0) ? ecol : ecol - 1'b1;
    col_r  = (ecol == w_eff - 1'b1) ? ecol : ecol + 1'b1;
    unique case (tap)
      4'd0, 4'd1, 4'd2: row_sel = row_up;
      4'd3, 4'd4, 4'd5: row_sel = ebase;
      default:          row_sel = row_dn;
    endcase
    unique case (tap)
      4'd0, 4'd3, 4'd6: col_sel = col_l;
      4'd1, 4'd4, 4'd7: col_sel = ecol;
      default:          col_sel = col_r;
    endcase
    rd_addr = row_sel + LS_AW'(col_sel);
  end

  // tap counter and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      tap    <= '0;
      rd_vld <= 1'b0;
      rd_tap <= '0;
    end else begin
      rd_vld <= rd_en;
      rd_tap <= tap;
      if (state == S_IDLE) begin
        tap <= '0;
      end else if (rd_en) begin
        tap <= tap + 1'b1;
      end
    end
  end

  // ring line store
  c3ce_ram #(
    .WIDTH(PIX_W),
    .DEPTH(LS_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (do_write),
    .waddr(k_eff[LS_AW-1:0]),
    .wdata({in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red}),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // multiply-accumulate, one tap a cycle
  assign coef_all = {coeff_bottom_row, coeff_mid_row, coeff_top_row};
  assign coef     = $signed(coef_all[rd_tap*8 +: 8]);

  // products at full sum width, both operands sign-extended
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      prod[i] = $signed({1'b0, rd_data[i*8 +: 8]}) * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      weight <= '0;
      for (int i = 0; i < NCH; i++) acc[i] <= '0;
    end else if (rd_vld) begin
      weight <= weight + WGT_W'(coef);
      for (int i = 0; i < NCH; i++) begin
        acc[i] <= acc[i] + prod[i];
      end
    end
  end

  // magnitudes for the divider
  assign zero_w  = (weight == '0);
  assign div_den = DEN_W'(weight[WGT_W-1] ? -weight : weight);
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      div_num[i] = acc[i][SUM_W-1] ? SUM_W'(-acc[i]) : SUM_W'(acc[i]);
    end
  end

  c3ce_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // sign of the truncated quotient, zero when the weight is zero
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      if (zero_w) res_ch[i] = '0;
      else if (acc[i][SUM_W-1] ^ weight[WGT_W-1]) res_ch[i] = 8'(-div_quo[i]);
      else res_ch[i] = div_quo[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_data.out_red     <= res_ch[0];
      out_data.out_green   <= res_ch[1];
      out_data.out_blue    <= res_ch[2];
      out_data.out_alpha   <= res_ch[3];
      out_data.frame_end   <= last_out;
      out_data.zero_weight <= zero_w;
    end
  end

endmodule
